/* rtl/socket_record_deframer_assert.svh */
// Assertion macros used by the record deframer port checker.
`ifndef SOCKET_RECORD_DEFRAMER_ASSERT_SVH
`define SOCKET_RECORD_DEFRAMER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/srd_pkg.sv */
// Types and constants of the socket record deframer.
package srd_pkg;

    localparam logic [2:0] EV_HEARTBEAT = 3'd0;
    localparam logic [2:0] EV_SHORT     = 3'd1;
    localparam logic [2:0] EV_BADSIG    = 3'd2;
    localparam logic [2:0] EV_CLASS_A   = 3'd3;
    localparam logic [2:0] EV_CLASS_B   = 3'd4;

    localparam logic [7:0] HEARTBEAT_BYTE = 8'hFF;
    localparam logic [5:0] TYPE_KNOWN_MAX = 6'o40;
    localparam logic [5:0] TYPE_DISCRETE  = 6'o05;

    // Position signatures of a class B record, by byte position.
    localparam logic [3:0][1:0] SIG_B = {2'd1, 2'd2, 2'd3, 2'd0};

    localparam int DATA_W = 72;

    typedef struct packed {
        logic [2:0]      ev;
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } t_frame;

    typedef struct packed {
        logic [5:0]  word_type;
        logic [17:0] word_value;
        logic        type_known;
        logic [3:0]  masks;
        logic [3:0]  levels;
    } t_decode;

endpackage

/* rtl/srd_framer.sv */
// Signature checking and partial record storage of the deframer.
module srd_framer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_emit,
    output srd_pkg::t_frame   o_frame
);

    logic [2:0][7:0] r_held;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic            held_we;
    logic [3:0][7:0] buf_bytes;
    logic [1:0]      sig;
    logic            ok_a;
    logic            ok_b;
    logic [2:0]      count_p1;

    assign sig      = i_byte[7:6];
    assign count_p1 = {1'b0, r_count} + 3'd1;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < r_count) begin
                buf_bytes[j] = r_held[j];
            end else if (2'(j) == r_count) begin
                buf_bytes[j] = i_byte;
            end else begin
                buf_bytes[j] = '0;
            end
        end
        buf_bytes[3] = (r_count == 2'd3) ? i_byte : 8'h00;
    end

    // Held bytes already passed the check, so only positions up to the new byte matter.
    always_comb begin
        ok_a = 1'b1;
        ok_b = 1'b1;
        for (int j = 0; j < 4; j++) begin
            if (3'(j) <= {1'b0, r_count}) begin
                if (buf_bytes[j][7:6] != 2'(j)) begin
                    ok_a = 1'b0;
                end
                if (buf_bytes[j][7:6] != srd_pkg::SIG_B[j]) begin
                    ok_b = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_emit        = 1'b1;
        o_frame.ev    = srd_pkg::EV_BADSIG;
        o_frame.count = count_p1;
        o_frame.bytes = buf_bytes;
        n_count       = 2'd0;
        held_we       = 1'b0;
        priority if (r_count == 2'd0 && i_byte == srd_pkg::HEARTBEAT_BYTE) begin
            o_frame.ev = srd_pkg::EV_HEARTBEAT;
        end else if (r_count != 2'd0 && sig == 2'd0) begin
            // The fragment is reported and the new byte opens the next record.
            o_frame.ev = srd_pkg::EV_SHORT;
            n_count    = 2'd1;
            held_we    = 1'b1;
        end else if (!ok_a && !ok_b) begin
            o_frame.ev = srd_pkg::EV_BADSIG;
        end else if (r_count == 2'd3) begin
            o_frame.ev = ok_a ? srd_pkg::EV_CLASS_A : srd_pkg::EV_CLASS_B;
        end else begin
            o_emit  = 1'b0;
            n_count = r_count + 2'd1;
            held_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

    // A short record restarts at slot 0; otherwise the byte goes to the next free slot.
    always_ff @(posedge i_clk) begin
        if (i_step && held_we) begin
            if (o_emit) begin
                r_held[0] <= i_byte;
            end else begin
                r_held[r_count] <= i_byte;
            end
        end
    end

endmodule

/* rtl/srd_decode.sv */
// Field decode of a complete class B record.
module srd_decode (
    input  srd_pkg::t_frame  i_frame,
    output srd_pkg::t_decode o_dec
);

    logic [5:0]  word_type;
    logic [17:0] word_value;
    logic [3:0]  masks;

    assign word_type  = i_frame.bytes[0][5:0];
    assign word_value = {i_frame.bytes[1][5:0], i_frame.bytes[2][5:0], i_frame.bytes[3][5:0]};
    assign masks      = word_value[4:1];

    always_comb begin
        o_dec = '0;
        if (i_frame.ev == srd_pkg::EV_CLASS_B) begin
            o_dec.word_type  = word_type;
            o_dec.word_value = word_value;
            o_dec.type_known = (word_type <= srd_pkg::TYPE_KNOWN_MAX);
            if (word_type == srd_pkg::TYPE_DISCRETE) begin
                o_dec.masks  = masks;
                o_dec.levels = word_value[13:10] & masks;
            end
        end
    end

endmodule

/* rtl/socket_record_deframer.sv */
// Top level of the socket record deframer.
// The slave channel takes one raw byte per word. Bits 7..6 of each byte are a
// position signature; four bytes in order 0,1,2,3 form a class A record and
// 0,3,2,1 a class B record. The master channel gives at most one result word
// per byte: a heartbeat, a short record, a bad signature or a complete record,
// with the reported bytes and, for class B, the decoded type, value and the
// discrete mask and level bits.
// A byte sits in the input register, is framed and decoded there, and its
// result is loaded into the output register, which drives o_m_axis_tvalid,
// once that register is empty or its word is being taken. One byte per cycle
// is accepted as long as the receiver takes results; the rate is set by the
// single framing stage.
// When the receiver stalls, the output register holds its word and the input
// register keeps one further byte; o_s_axis_tready drops only when both are
// full. Reset empties both registers and drops any partial record.
module socket_record_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // rx_byte[7:0]
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // event_res[2:0], byte_count[5:3], first_byte[13:6], second_byte[21:14],
    // third_byte[29:22], fourth_byte[37:30], word_type[43:38],
    // word_value[61:44], type_known[62], discrete_masks[66:63],
    // discrete_levels[70:67], zero fill[71]
    output logic [srd_pkg::DATA_W-1:0]  o_m_axis_tdata
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_out_valid;
    logic [srd_pkg::DATA_W-1:0] r_out_data;
    logic                       step;
    logic                       emit;
    srd_pkg::t_frame            frame;
    srd_pkg::t_decode           dec;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    srd_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_frame (frame)
    );

    srd_decode u_decode (
        .i_frame (frame),
        .o_dec   (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_data <= {1'b0, dec.levels, dec.masks, dec.type_known, dec.word_value,
                           dec.word_type, frame.bytes[3], frame.bytes[2], frame.bytes[1],
                           frame.bytes[0], frame.count, frame.ev};
        end
    end

endmodule

/* rtl/srd_checker.sv */
// Port-level assertions of the socket record deframer and their bind.
`include "socket_record_deframer_assert.svh"

module srd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [srd_pkg::DATA_W-1:0]  o_m_axis_tdata
);

    logic [2:0] ev;
    logic [2:0] cnt;
    logic       stalled;

    assign ev      = o_m_axis_tdata[2:0];
    assign cnt     = o_m_axis_tdata[5:3];
    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;

    // A stalled result word must not change or vanish.
    `SRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "result word changed while stalled")

    // A heartbeat reports exactly the 0xFF byte.
    `SRD_ASSERT_NOW(a_heartbeat, i_clk, i_rst_n,
        o_m_axis_tvalid && ev == srd_pkg::EV_HEARTBEAT,
        cnt == 3'd1 && o_m_axis_tdata[13:6] == srd_pkg::HEARTBEAT_BYTE,
        "heartbeat with wrong byte or count")

    // Complete records always carry four bytes.
    `SRD_ASSERT_NOW(a_record_len, i_clk, i_rst_n,
        o_m_axis_tvalid && (ev == srd_pkg::EV_CLASS_A || ev == srd_pkg::EV_CLASS_B),
        cnt == 3'd4, "complete record without four bytes")

    // Decoded fields stay zero on anything but a class B record.
    `SRD_ASSERT_NOW(a_decode_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && ev != srd_pkg::EV_CLASS_B,
        o_m_axis_tdata[70:38] == '0, "decoded fields set outside class B")

endmodule

bind socket_record_deframer srd_checker u_srd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

/* test/socket_record_deframer_checker.sv */
// Checker that watches both channels of the deframer, predicts each result word and compares.
module socket_record_deframer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    input  logic                        i_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // rx_byte[7:0]
    input  logic                        i_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // event_res[2:0], byte_count[5:3], first_byte[13:6], second_byte[21:14],
    // third_byte[29:22], fourth_byte[37:30], word_type[43:38],
    // word_value[61:44], type_known[62], discrete_masks[66:63],
    // discrete_levels[70:67], zero fill[71]
    input  logic [srd_pkg::DATA_W-1:0]  i_m_axis_tdata,
    output int                          o_pending,
    output int                          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // Same layout as the result word, highest field first.
    typedef struct packed {
        logic        fill;
        logic [3:0]  levels;
        logic [3:0]  masks;
        logic        known;
        logic [17:0] value;
        logic [5:0]  wtype;
        logic [7:0]  byte4;
        logic [7:0]  byte3;
        logic [7:0]  byte2;
        logic [7:0]  byte1;
        logic [2:0]  count;
        logic [2:0]  ev;
    } t_record_word;

    logic [2:0][7:0] held;
    logic [1:0]      held_n = 2'd0;
    t_record_word    expected_words [$];
    int              errors = 0;
    bit              word_bad;

    function automatic void push_word(input logic [2:0] ev, input int cnt,
                                      input logic [3:0][7:0] run);
        t_record_word w;
        logic [17:0]  v;
        w = '0;
        w.ev    = ev;
        w.count = 3'(cnt);
        w.byte1 = run[0];
        if (cnt > 1) w.byte2 = run[1];
        if (cnt > 2) w.byte3 = run[2];
        if (cnt > 3) w.byte4 = run[3];
        if (ev == srd_pkg::EV_CLASS_B) begin
            v       = {run[1][5:0], run[2][5:0], run[3][5:0]};
            w.wtype = run[0][5:0];
            w.value = v;
            w.known = (run[0][5:0] <= srd_pkg::TYPE_KNOWN_MAX);
            if (run[0][5:0] == srd_pkg::TYPE_DISCRETE) begin
                w.masks  = v[4:1];
                w.levels = v[13:10] & v[4:1];
            end
        end
        expected_words.push_back(w);
    endfunction

    // Advances the framing state by one byte and queues any result it causes.
    function automatic void frame_byte(input logic [7:0] rx);
        logic [3:0][7:0] run;
        int              n;
        logic            ok_a;
        logic            ok_b;
        run = '0;
        n   = int'(held_n);
        if (n == 0 && rx == srd_pkg::HEARTBEAT_BYTE) begin
            run[0] = rx;
            push_word(srd_pkg::EV_HEARTBEAT, 1, run);
            return;
        end
        for (int i = 0; i < n; i++) run[i] = held[i];
        run[n] = rx;
        // A record start in the middle of a record cuts the held one short.
        if (n > 0 && rx[7:6] == 2'd0) begin
            push_word(srd_pkg::EV_SHORT, n + 1, run);
            held[0] = rx;
            held_n  = 2'd1;
            return;
        end
        ok_a = 1'b1;
        ok_b = 1'b1;
        for (int i = 0; i <= n; i++) begin
            if (run[i][7:6] != 2'(i)) ok_a = 1'b0;
            if (run[i][7:6] != 2'(4 - i)) ok_b = 1'b0;
        end
        if (!ok_a && !ok_b) begin
            push_word(srd_pkg::EV_BADSIG, n + 1, run);
            held_n = 2'd0;
        end else if (n == 3) begin
            push_word(ok_a ? srd_pkg::EV_CLASS_A : srd_pkg::EV_CLASS_B, 4, run);
            held_n = 2'd0;
        end else begin
            held[n] = rx;
            held_n  = 2'(n + 1);
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            word_bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_record_word got;
        t_record_word want;
        if (!i_rst_n) begin
            held_n = 2'd0;
            expected_words.delete();
        end else begin
            // Results trail their byte, so outputs are matched first.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_record_word'(i_m_axis_tdata);
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected, expected none, actual 0x%0h",
                             $time, i_m_axis_tdata);
                    errors++;
                end else begin
                    want     = expected_words.pop_front();
                    word_bad = 1'b0;
                    check_field("event_res", 32'(want.ev), 32'(got.ev));
                    check_field("byte_count", 32'(want.count), 32'(got.count));
                    check_field("first_byte", 32'(want.byte1), 32'(got.byte1));
                    check_field("second_byte", 32'(want.byte2), 32'(got.byte2));
                    check_field("third_byte", 32'(want.byte3), 32'(got.byte3));
                    check_field("fourth_byte", 32'(want.byte4), 32'(got.byte4));
                    check_field("word_type", 32'(want.wtype), 32'(got.wtype));
                    check_field("word_value", 32'(want.value), 32'(got.value));
                    check_field("type_known", 32'(want.known), 32'(got.known));
                    check_field("discrete_masks", 32'(want.masks), 32'(got.masks));
                    check_field("discrete_levels", 32'(want.levels), 32'(got.levels));
                    check_field("zero fill", 32'(want.fill), 32'(got.fill));
                    if (word_bad) errors++;
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) frame_byte(i_s_axis_tdata);
        end
        o_pending <= expected_words.size();
        o_errors  <= errors;
    end

endmodule

/* test/socket_record_deframer_tb.sv */
// Testbench top of the record deframer: drives the byte stream and gives the verdict.
module socket_record_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 190;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata  = 8'h00;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [srd_pkg::DATA_W-1:0] m_tdata;
    int                         pending;
    int                         errors;
    int                         cycle_count = 0;
    int                         send_idle_pct = 0;
    int                         stall_pct = 0;
    int                         phase_idle [4] = '{0, 75, 0, 10};
    int                         phase_stall [4] = '{0, 0, 75, 10};

    // Heartbeats, lone bad bytes, both record classes with the discrete type and
    // the type-table edge, a bad second byte, short records of two and four
    // bytes, and a bad fourth byte.
    logic [7:0] directed_bytes [$] = '{
        8'hFF, 8'h40, 8'hFE,
        8'h00, 8'h7F, 8'hBF, 8'hC0,
        8'h05, 8'hFF, 8'hBF, 8'h7F,
        8'h3F, 8'hC0, 8'h80, 8'h40,
        8'h20, 8'hEA, 8'h95, 8'h6A,
        8'h00, 8'h80,
        8'h21, 8'h00,
        8'h41, 8'h82, 8'h13,
        8'h4F, 8'h8F, 8'h40
    };

    socket_record_deframer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    socket_record_deframer_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [5:0] pick_type();
        case ($urandom_range(3))
            0: return srd_pkg::TYPE_DISCRETE;
            1: return $urandom_range(1) ? srd_pkg::TYPE_KNOWN_MAX
                                        : srd_pkg::TYPE_KNOWN_MAX + 6'd1;
            default: return 6'($urandom_range(63));
        endcase
    endfunction

    function automatic logic [3:0][7:0] make_record(input logic class_b);
        logic [3:0][7:0] r;
        for (int i = 0; i < 4; i++) begin
            r[i][5:0] = 6'($urandom_range(63));
            r[i][7:6] = class_b ? 2'(4 - i) : 2'(i);
        end
        if (class_b) r[0][5:0] = pick_type();
        return r;
    endfunction

    // Mostly whole records; the rest are cut-off records, wrong signatures,
    // raw noise and heartbeats.
    task automatic random_phase(input int n_items);
        logic [3:0][7:0] rec;
        logic [1:0]      sig;
        int              pick;
        int              cut;
        int              sent;
        sent = 0;
        while (sent < n_items) begin
            rec  = make_record(1'($urandom_range(1)));
            pick = $urandom_range(99);
            if (pick < 60) begin
                for (int i = 0; i < 4; i++) send_byte(rec[i]);
                sent += 4;
            end else if (pick < 75) begin
                // The next record start ends this one early.
                cut = $urandom_range(1, 3);
                for (int i = 0; i < cut; i++) send_byte(rec[i]);
                sent += cut;
            end else if (pick < 88) begin
                cut = $urandom_range(0, 3);
                for (int i = 0; i < cut; i++) send_byte(rec[i]);
                do sig = 2'($urandom_range(1, 3)); while (sig == rec[cut][7:6]);
                send_byte({sig, 6'($urandom_range(63))});
                sent += cut + 1;
            end else if (pick < 95) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                send_byte(srd_pkg::HEARTBEAT_BYTE);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        wait_drained();
        // Each phase ends with the sender held off until every result is back.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            random_phase(RANDOM_PER_PHASE);
            wait_drained();
        end
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* socket_record_deframer.f */
+incdir+rtl
rtl/srd_pkg.sv
rtl/srd_framer.sv
rtl/srd_decode.sv
rtl/socket_record_deframer.sv
rtl/srd_checker.sv
test/socket_record_deframer_checker.sv
test/socket_record_deframer_tb.sv
